/* rtl/assert_macros.svh */
// Assertion macros for the RTL modules.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/dae_pkg.sv */
// Types, constants and helper functions for the dynamic array element remover.
// No dependencies.
package dae_pkg;

    localparam int CNT_W   = 16;
    localparam int TGT_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [BYTE_W-1:0] FIELD_MARK_RST    = 8'd30;
    localparam logic [BYTE_W-1:0] VALUE_MARK_RST    = 8'd29;
    localparam logic [BYTE_W-1:0] SUBVALUE_MARK_RST = 8'd28;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FIELD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VALUE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SUBVALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MARK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MARK      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBVALUE_MARK   = 3'd5;

    typedef struct packed {
        logic signed [TGT_W-1:0] target_field;
        logic signed [TGT_W-1:0] target_value;
        logic signed [TGT_W-1:0] target_subvalue;
        logic [BYTE_W-1:0]       field_mark;
        logic [BYTE_W-1:0]       value_mark;
        logic [BYTE_W-1:0]       subvalue_mark;
    } t_cfg;

    // at most one bit set; field outranks value outranks subvalue
    typedef struct packed {
        logic field;
        logic value;
        logic subvalue;
    } t_byte_class;

    typedef struct packed {
        logic [CNT_W-1:0] field_count;
        logic [CNT_W-1:0] value_count;
        logic [CNT_W-1:0] subvalue_count;
    } t_counts;

    // removal test at one level, target t >= 1
    function automatic logic level_drop(input logic [CNT_W-1:0] cnt,
                                        input logic [TGT_W-1:0] t,
                                        input logic is_delim);
        logic [TGT_W-1:0] t_m1;
        t_m1 = t - TGT_W'(1);
        if (is_delim) begin
            return ((t != TGT_W'(1)) && (cnt == t_m1)) ||
                   ((t == TGT_W'(1)) && (cnt == CNT_ONE));
        end
        return cnt == t;
    endfunction

endpackage

/* rtl/dae_cfg.sv */
// Configuration register file: targets and delimiter codes.
// Depends on dae_pkg.
module dae_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [dae_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [dae_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output dae_pkg::t_cfg                   o_cfg
);
    dae_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_field    <= '0;
            r_cfg.target_value    <= '0;
            r_cfg.target_subvalue <= '0;
            r_cfg.field_mark      <= dae_pkg::FIELD_MARK_RST;
            r_cfg.value_mark      <= dae_pkg::VALUE_MARK_RST;
            r_cfg.subvalue_mark   <= dae_pkg::SUBVALUE_MARK_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                dae_pkg::CFG_TARGET_FIELD:    r_cfg.target_field    <= i_wr_data;
                dae_pkg::CFG_TARGET_VALUE:    r_cfg.target_value    <= i_wr_data;
                dae_pkg::CFG_TARGET_SUBVALUE: r_cfg.target_subvalue <= i_wr_data;
                dae_pkg::CFG_FIELD_MARK:      r_cfg.field_mark      <= i_wr_data[7:0];
                dae_pkg::CFG_VALUE_MARK:      r_cfg.value_mark      <= i_wr_data[7:0];
                dae_pkg::CFG_SUBVALUE_MARK:   r_cfg.subvalue_mark   <= i_wr_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

/* rtl/dae_decide.sv */
// Per-byte decision: delimiter class and keep/remove flag.
// Depends on dae_pkg.
module dae_decide (
    input  logic [dae_pkg::BYTE_W-1:0] i_byte,
    input  dae_pkg::t_cfg              i_cfg,
    input  dae_pkg::t_counts           i_counts,
    output dae_pkg::t_byte_class       o_class,
    output logic                       o_keep
);
    logic                      is_fm, is_vm, is_sm;
    logic                      all_zero, any_neg;
    logic [dae_pkg::TGT_W-1:0] f, v, s, fe, ve;
    logic                      drop;

    always_comb begin
        f = i_cfg.target_field;
        v = i_cfg.target_value;
        s = i_cfg.target_subvalue;
        is_fm = (i_byte == i_cfg.field_mark);
        is_vm = !is_fm && (i_byte == i_cfg.value_mark);
        is_sm = !is_fm && !is_vm && (i_byte == i_cfg.subvalue_mark);
        all_zero = (f == '0) && (v == '0) && (s == '0);
        any_neg  = f[dae_pkg::TGT_W-1] | v[dae_pkg::TGT_W-1] | s[dae_pkg::TGT_W-1];
        fe = (f == '0) ? dae_pkg::TGT_W'(1) : f;
        ve = (v == '0) ? dae_pkg::TGT_W'(1) : v;
        drop = 1'b0;
        priority if (all_zero) begin
            drop = 1'b1;
        end else if (any_neg) begin
            drop = 1'b0;
        end else if ((v == '0) && (s == '0)) begin
            drop = dae_pkg::level_drop(i_counts.field_count, f, is_fm);
        end else if ((i_counts.field_count == fe) && !is_fm) begin
            if (s == '0) begin
                drop = dae_pkg::level_drop(i_counts.value_count, v, is_vm);
            end else if ((i_counts.value_count == ve) && !is_vm) begin
                drop = dae_pkg::level_drop(i_counts.subvalue_count, s, is_sm);
            end
        end else begin
            drop = 1'b0;
        end
        o_class.field    = is_fm;
        o_class.value    = is_vm;
        o_class.subvalue = is_sm;
        o_keep = !drop;
    end
endmodule

/* rtl/dae_counters.sv */
// Field, value and subvalue position counters, saturating, reset by last byte.
// Depends on dae_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dae_counters (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  dae_pkg::t_byte_class i_class,
    input  logic                 i_last,
    output dae_pkg::t_counts     o_counts
);
    dae_pkg::t_counts r_cnt, n_cnt;

    function automatic logic [dae_pkg::CNT_W-1:0] sat_inc(
            input logic [dae_pkg::CNT_W-1:0] c);
        return (c == dae_pkg::CNT_MAX) ? c : c + dae_pkg::CNT_W'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        priority if (i_class.field) begin
            n_cnt.field_count    = sat_inc(r_cnt.field_count);
            n_cnt.value_count    = dae_pkg::CNT_ONE;
            n_cnt.subvalue_count = dae_pkg::CNT_ONE;
        end else if (i_class.value) begin
            n_cnt.value_count    = sat_inc(r_cnt.value_count);
            n_cnt.subvalue_count = dae_pkg::CNT_ONE;
        end else if (i_class.subvalue) begin
            n_cnt.subvalue_count = sat_inc(r_cnt.subvalue_count);
        end else begin
            n_cnt = r_cnt;
        end
        if (i_last) begin
            n_cnt.field_count    = dae_pkg::CNT_ONE;
            n_cnt.value_count    = dae_pkg::CNT_ONE;
            n_cnt.subvalue_count = dae_pkg::CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt.field_count    <= dae_pkg::CNT_ONE;
            r_cnt.value_count    <= dae_pkg::CNT_ONE;
            r_cnt.subvalue_count <= dae_pkg::CNT_ONE;
        end else if (i_adv) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_counts = r_cnt;

    `ASSERT_CLK(a_last_restarts, i_clk, i_rst_n, (i_adv && i_last) |=> (r_cnt.field_count == dae_pkg::CNT_ONE && r_cnt.value_count == dae_pkg::CNT_ONE && r_cnt.subvalue_count == dae_pkg::CNT_ONE))
    `ASSERT_CLK(a_never_zero, i_clk, i_rst_n, (r_cnt.field_count != '0) && (r_cnt.value_count != '0) && (r_cnt.subvalue_count != '0))
    `ASSERT_CLK(a_field_clears_lower, i_clk, i_rst_n, (i_adv && i_class.field) |=> (r_cnt.value_count == dae_pkg::CNT_ONE && r_cnt.subvalue_count == dae_pkg::CNT_ONE))
    `ASSERT_CLK(a_data_holds, i_clk, i_rst_n, (!i_adv || (!i_last && !i_class.field && !i_class.value && !i_class.subvalue)) |=> $stable(r_cnt))
endmodule

/* rtl/dynamic_array_element_remover.sv */
// Dynamic array element remover, top level: input register, decision, result register.
// Bytes pass input register, single decision stage, result register in that order.
// One byte accepted per cycle while the result side does not stall.
// Reset (synchronous, active low) clears valids, counters to 1, targets 0, marks 30/29/28.
// Depends on dae_pkg, dae_cfg, dae_decide, dae_counters.
module dynamic_array_element_remover (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tuser,   // [0] keep
    output logic        o_m_axis_tlast,   // out_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    dae_pkg::t_cfg        cfg;
    dae_pkg::t_counts     counts;
    dae_pkg::t_byte_class cls;
    logic                 keep;
    logic                 adv;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_keep;
    logic       r_out_last;

    assign o_cfg_ready = 1'b1;

    dae_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // item moves from input register to result register
    assign adv = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    dae_decide u_decide (
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .i_counts (counts),
        .o_class  (cls),
        .o_keep   (keep)
    );

    dae_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_class  (cls),
        .i_last   (r_in_last),
        .o_counts (counts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_byte <= r_in_byte;
            r_out_keep <= keep;
            r_out_last <= r_in_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_keep;
    assign o_m_axis_tlast  = r_out_last;
endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for dynamic_array_element_remover: streams delimited byte strings,
// predicts the keep flag of every byte and compares each output transaction in order.
// Depends on dae_pkg and the RTL of the block.
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_BYTES  = 600;
    localparam int PRINT_MAX   = 20;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} t_sink_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       last;
    } t_kept_byte;

    // keep-flag predictor and in-order result store
    class t_keep_predictor;
        logic signed [15:0] tgt_field, tgt_value, tgt_subvalue;
        logic [7:0]         fmark, vmark, smark;
        logic [15:0]        fcnt, vcnt, scnt;
        t_kept_byte         expected_bytes[$];
        int                 mismatches, checked, removed;

        function new();
            tgt_field = '0;
            tgt_value = '0;
            tgt_subvalue = '0;
            fmark = dae_pkg::FIELD_MARK_RST;
            vmark = dae_pkg::VALUE_MARK_RST;
            smark = dae_pkg::SUBVALUE_MARK_RST;
            fcnt = 16'd1;
            vcnt = 16'd1;
            scnt = 16'd1;
        endfunction

        function void set_reg(logic [dae_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
            case (idx)
                dae_pkg::CFG_TARGET_FIELD:    tgt_field = d;
                dae_pkg::CFG_TARGET_VALUE:    tgt_value = d;
                dae_pkg::CFG_TARGET_SUBVALUE: tgt_subvalue = d;
                dae_pkg::CFG_FIELD_MARK:      fmark = d[7:0];
                dae_pkg::CFG_VALUE_MARK:      vmark = d[7:0];
                dae_pkg::CFG_SUBVALUE_MARK:   smark = d[7:0];
                default: ;
            endcase
        endfunction

        function bit level_hit(int cnt, int t, bit delim);
            if (delim)
                return (t > 1 && cnt == t - 1) || (t == 1 && cnt == 1);
            return cnt == t;
        endfunction

        function logic [15:0] bump(logic [15:0] c);
            return (c == 16'hFFFF) ? c : c + 16'd1;
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            int f, v, s, fc, vc, sc, fe, ve;
            bit is_f, is_v, is_s, drop;
            t_kept_byte r;
            f = tgt_field;
            v = tgt_value;
            s = tgt_subvalue;
            fc = fcnt;
            vc = vcnt;
            sc = scnt;
            is_f = (b == fmark);
            is_v = !is_f && (b == vmark);
            is_s = !is_f && !is_v && (b == smark);
            drop = 1'b0;
            if (f == 0 && v == 0 && s == 0) begin
                drop = 1'b1;
            end else if (f < 0 || v < 0 || s < 0) begin
                drop = 1'b0;
            end else if (v == 0 && s == 0) begin
                drop = level_hit(fc, f, is_f);
            end else begin
                fe = (f == 0) ? 1 : f;
                if (fc == fe && !is_f) begin
                    if (s == 0) begin
                        drop = level_hit(vc, v, is_v);
                    end else begin
                        ve = (v == 0) ? 1 : v;
                        if (vc == ve && !is_v)
                            drop = level_hit(sc, s, is_s);
                    end
                end
            end
            if (is_f) begin
                fcnt = bump(fcnt);
                vcnt = 16'd1;
                scnt = 16'd1;
            end else if (is_v) begin
                vcnt = bump(vcnt);
                scnt = 16'd1;
            end else if (is_s) begin
                scnt = bump(scnt);
            end
            if (l) begin
                fcnt = 16'd1;
                vcnt = 16'd1;
                scnt = 16'd1;
            end
            r.data = b;
            r.keep = !drop;
            r.last = l;
            expected_bytes.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_MAX)
                $display("%0t ERROR: %s", $realtime, what);
        endtask

        task check_result(logic [7:0] b, logic k, logic l);
            t_kept_byte e;
            if (expected_bytes.size() == 0) begin
                report($sformatf("output byte %02h with nothing outstanding", b));
                return;
            end
            e = expected_bytes.pop_front();
            checked++;
            if (!e.keep)
                removed++;
            if (b !== e.data)
                report($sformatf("out_byte %02h, predicted %02h", b, e.data));
            if (k !== e.keep)
                report($sformatf("keep %b for byte %02h, predicted %b", k, e.data, e.keep));
            if (l !== e.last)
                report($sformatf("out_last %b for byte %02h, predicted %b", l, e.data, e.last));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic [7:0]                    s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [dae_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                   cfg_data = '0;
    wire                           s_tready, m_tvalid, m_tuser, m_tlast, cfg_ready;
    wire  [7:0]                    m_tdata;

    t_keep_predictor model = new();
    t_sink_mode      rx_mode = SINK_ALWAYS;
    int              long_holds_asked = 0;
    bit              src_idle_en = 1'b0;
    int              burst_left = 0;
    int              bytes_sent = 0;
    int              settings_used = 0;
    int              cycles = 0;
    logic [7:0]      str_q[$];

    dynamic_array_element_remover dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("dynamic_array_element_remover: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            model.check_result(m_tdata, m_tuser, m_tlast);
    end

    // result side stalls
    initial begin : result_sink
        int cyc;
        int held;
        cyc = 0;
        held = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (long_holds_asked > held) begin
                held++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            case (rx_mode)
                SINK_ALWAYS: m_tready <= 1'b1;
                SINK_RANDOM: m_tready <= ($urandom_range(0, 99) < 60);
                default:     m_tready <= ((cyc % 7) < 4);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        if (src_idle_en && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        model.note_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_str();
        foreach (str_q[i])
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (model.expected_bytes.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dae_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        model.set_reg(idx, d);
    endtask

    task automatic program_regs(input int f, input int v, input int s,
                                input logic [7:0] fm, input logic [7:0] vm,
                                input logic [7:0] sm);
        write_reg(dae_pkg::CFG_TARGET_FIELD, 16'(f));
        write_reg(dae_pkg::CFG_TARGET_VALUE, 16'(v));
        write_reg(dae_pkg::CFG_TARGET_SUBVALUE, 16'(s));
        write_reg(dae_pkg::CFG_FIELD_MARK, {8'h00, fm});
        write_reg(dae_pkg::CFG_VALUE_MARK, {8'h00, vm});
        write_reg(dae_pkg::CFG_SUBVALUE_MARK, {8'h00, sm});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_target();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return -1 - int'($urandom_range(0, 32767));
        if (r == 1)
            return 32767;
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == model.fmark || b == model.vmark || b == model.smark)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // one string: mostly well-formed nesting, sometimes raw bytes with stray marks
    task automatic send_string(input bit noisy);
        int nf, nv, ns, r;
        str_q.delete();
        if (noisy) begin
            repeat ($urandom_range(1, 12)) begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    str_q.push_back(model.fmark);
                else if (r == 1)
                    str_q.push_back(model.vmark);
                else if (r == 2)
                    str_q.push_back(model.smark);
                else
                    str_q.push_back(8'($urandom_range(0, 255)));
            end
        end else begin
            nf = $urandom_range(1, 4);
            for (int fi = 0; fi < nf; fi++) begin
                if (fi > 0)
                    str_q.push_back(model.fmark);
                nv = $urandom_range(1, 3);
                for (int vi = 0; vi < nv; vi++) begin
                    if (vi > 0)
                        str_q.push_back(model.vmark);
                    ns = $urandom_range(1, 3);
                    for (int si = 0; si < ns; si++) begin
                        if (si > 0)
                            str_q.push_back(model.smark);
                        repeat ($urandom_range(0, 2))
                            str_q.push_back(plain_byte());
                    end
                end
            end
            if (str_q.size() == 0)
                str_q.push_back(plain_byte());
        end
        send_str();
    endtask

    initial begin : stimulus
        int f, v, s, n, start;
        logic [7:0] fm, vm, sm;
        bit paused;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // targets all zero after reset: everything removed
        str_q = {8'h00, dae_pkg::FIELD_MARK_RST, 8'hFF};
        send_str();
        drain_results();
        program_regs(2, 0, 0, dae_pkg::FIELD_MARK_RST, dae_pkg::VALUE_MARK_RST,
                     dae_pkg::SUBVALUE_MARK_RST);
        str_q = {8'h41, dae_pkg::FIELD_MARK_RST, 8'h42, dae_pkg::FIELD_MARK_RST, 8'h43};
        send_str();
        drain_results();
        // zero field number with nonzero lower numbers means field 1
        program_regs(0, 2, 1, dae_pkg::FIELD_MARK_RST, dae_pkg::VALUE_MARK_RST,
                     dae_pkg::SUBVALUE_MARK_RST);
        str_q = {8'h41, dae_pkg::VALUE_MARK_RST, 8'h42, dae_pkg::SUBVALUE_MARK_RST, 8'h43,
                 dae_pkg::VALUE_MARK_RST, 8'h44};
        send_str();
        drain_results();
        program_regs(-1, 0, 0, dae_pkg::FIELD_MARK_RST, dae_pkg::VALUE_MARK_RST,
                     dae_pkg::SUBVALUE_MARK_RST);
        str_q = {8'h41, dae_pkg::FIELD_MARK_RST, 8'h42};
        send_str();
        drain_results();
        // field beyond the end of the string
        program_regs(5, 0, 0, dae_pkg::FIELD_MARK_RST, dae_pkg::VALUE_MARK_RST,
                     dae_pkg::SUBVALUE_MARK_RST);
        str_q = {8'h41, dae_pkg::FIELD_MARK_RST, 8'h42};
        send_str();
        drain_results();
        // all marks equal: field mark wins
        program_regs(2, 0, 0, 8'h7C, 8'h7C, 8'h7C);
        str_q = {8'h41, 8'h7C, 8'h42};
        send_str();

        start = bytes_sent;
        for (int p = 0; bytes_sent - start < RAND_BYTES; p++) begin
            drain_results();
            fm = dae_pkg::FIELD_MARK_RST;
            vm = dae_pkg::VALUE_MARK_RST;
            sm = dae_pkg::SUBVALUE_MARK_RST;
            if (p == 0) begin
                f = 32767; v = 0; s = 0;
                fm = 8'h00; vm = 8'hFF; sm = 8'h80;
            end else if (p == 1) begin
                f = 1; v = 1; s = 32767;
                fm = 8'hFF; vm = 8'h00; sm = 8'h7F;
            end else if (p == 2) begin
                f = 2; v = -32768; s = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                f = 0; v = 0; s = 0;
            end else begin
                f = pick_target();
                v = pick_target();
                s = pick_target();
                if ($urandom_range(0, 1) == 1) begin
                    fm = 8'($urandom_range(0, 255));
                    vm = ($urandom_range(0, 3) == 0) ? fm : 8'($urandom_range(0, 255));
                    sm = ($urandom_range(0, 3) == 0) ? vm : 8'($urandom_range(0, 255));
                end
            end
            program_regs(f, v, s, fm, vm, sm);
            if (p == 3) begin
                rx_mode <= SINK_RANDOM;
                src_idle_en = 1'b0;
                long_holds_asked <= long_holds_asked + 1;
            end else begin
                rx_mode <= t_sink_mode'($urandom_range(0, 2));
                src_idle_en = ($urandom_range(0, 3) != 0);
            end
            n = $urandom_range(30, 70);
            paused = 1'b0;
            for (int got = bytes_sent; bytes_sent - got < n; ) begin
                if (p == 5 && !paused && bytes_sent - got >= n / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                send_string($urandom_range(0, 4) == 0);
            end
        end

        drain_results();
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes under %0d register settings, %0d of them removed,",
                 model.checked, settings_used, model.removed);
        $display("with random stalls on both sides, a long result hold and a full drain pause.");
        if (model.mismatches == 0 && model.expected_bytes.size() == 0)
            $display("dynamic_array_element_remover: match");
        else
            $display("dynamic_array_element_remover: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/dae_pkg.sv
rtl/dae_cfg.sv
rtl/dae_decide.sv
rtl/dae_counters.sv
rtl/dynamic_array_element_remover.sv
tb/tb_top.sv
